>>> rtl/smol_pkg.sv
// shared types and codes for the struct member offset layout block
package smol_pkg;

	// width of the alignment fields
	localparam int ALIGN_W = 13;
	// width of the declared bitfield width
	localparam int BITW_W = 7;
	// width of the member size and result byte fields
	localparam int BYTE_W = 32;

	// operation class decided by the front end
	typedef logic [1:0] op_t;
	localparam op_t OP_PLAIN  = 2'd0;	// plain member or zero-width bitfield
	localparam op_t OP_BITS   = 2'd1;	// bitfield with nonzero width, struct mode
	localparam op_t OP_UNION  = 2'd2;	// any member in union mode
	localparam op_t OP_FINISH = 2'd3;	// close the record and report totals

	// result kinds
	localparam logic KIND_MEMBER = 1'b0;
	localparam logic KIND_RECORD = 1'b1;

	// classified member handed from front to back
	typedef struct packed {
		op_t                 op;
		logic [BYTE_W-1:0]   tsize;	// bytes to add, zero where nothing is added
		logic [ALIGN_W-1:0]  align;	// normalized power-of-two alignment
		logic [BITW_W-1:0]   width;	// bitfield width
	} cmd_t;

	// one result beat
	typedef struct packed {
		logic                kind;
		logic [BYTE_W-1:0]   byte_value;
		logic [2:0]          bit_value;
		logic [ALIGN_W-1:0]  total_align;
		logic                padded;
		logic                overflow;
	} res_t;

endpackage

>>> rtl/struct_member_offset_layout.sv
// top level of the struct member offset layout block
// Lays out the members of one C-style struct or union, one member per beat, in
// declaration order. Each member beat returns one result beat with its byte offset
// and, for bitfields in struct mode, the bit offset inside that byte; a finish beat
// (func = 1) returns the record's total size, alignment, padding and overflow flags
// and clears the running state for the next record. union_mode is written through
// cfg_we / cfg_wdata and is not cleared by a finish. The block sustains one item
// per clock in both directions while the result side keeps popping: the per-member
// state update (close an open byte, align up with one carry-in add, then add the
// member size) is combinational in the back end, and that loop sets the rate. An
// accepted item passes through the command queue and then the result queue before
// it shows up on the result ports. Two-entry queues sit between input, back end
// and result ports, so a stalled result side does not stop input until both
// queues fill. There is no clearing pass after reset. SIZE_BITS (16 to 64) sets
// the width of the running size; byte_value carries its low 32 bits.
module struct_member_offset_layout #(
	parameter int SIZE_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          cfg_we,
	input  logic                          cfg_wdata,
	// input side
	input  logic                          push,
	output logic                          full,
	input  logic                          func,
	input  logic [smol_pkg::BYTE_W-1:0]   member_size,
	input  logic [smol_pkg::ALIGN_W-1:0]  member_align,
	input  logic                          is_bitfield,
	input  logic [smol_pkg::BITW_W-1:0]   bit_width,
	input  logic                          is_flexible,
	// result side
	output logic                          empty,
	input  logic                          pop,
	output logic                          kind,
	output logic [smol_pkg::BYTE_W-1:0]   byte_value,
	output logic [2:0]                    bit_value,
	output logic [smol_pkg::ALIGN_W-1:0]  total_align,
	output logic                          padded,
	output logic                          overflow
);

	localparam int CMD_W = $bits(smol_pkg::cmd_t);
	localparam int RES_W = $bits(smol_pkg::res_t);

	smol_pkg::cmd_t cmd_in;      // classified member entering the queue
	smol_pkg::cmd_t cmd_head;    // oldest classified member
	logic           cmd_empty;
	logic           cmd_take;    // back end consumes the head
	smol_pkg::res_t res_new;     // result built by the back end
	smol_pkg::res_t res_head;    // oldest waiting result
	logic           res_full;

	// classify incoming beats, holds the union_mode register
	smol_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.func         (func),
		.member_size  (member_size),
		.member_align (member_align),
		.is_bitfield  (is_bitfield),
		.bit_width    (bit_width),
		.is_flexible  (is_flexible),
		.cmd          (cmd_in)
	);

	// decouples classification from the layout state update
	smol_fifo #(
		.WIDTH (CMD_W),
		.DEPTH (2)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.wdata  (cmd_in),
		.pop    (cmd_take),
		.empty  (cmd_empty),
		.rdata  (cmd_head)
	);

	// running layout state, one member per cycle when the result queue has room
	smol_back #(
		.SIZE_BITS (SIZE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (!cmd_empty),
		.cmd       (cmd_head),
		.cmd_take  (cmd_take),
		.res_room  (!res_full),
		.res       (res_new)
	);

	// result queue seen from outside through empty / pop
	smol_fifo #(
		.WIDTH (RES_W),
		.DEPTH (2)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_take),
		.full   (res_full),
		.wdata  (res_new),
		.pop    (pop),
		.empty  (empty),
		.rdata  (res_head)
	);

	assign kind        = res_head.kind;
	assign byte_value  = res_head.byte_value;
	assign bit_value   = res_head.bit_value;
	assign total_align = res_head.total_align;
	assign padded      = res_head.padded;
	assign overflow    = res_head.overflow;

endmodule

>>> rtl/smol_fifo.sv
// small register queue used between the front, back and result ports
module smol_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] rdata
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wptr_q;
	logic [AW-1:0]    rptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

>>> rtl/smol_front.sv
// front end: mode register, alignment normalization and member classification
module smol_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_wdata,
	input  logic                          func,
	input  logic [smol_pkg::BYTE_W-1:0]   member_size,
	input  logic [smol_pkg::ALIGN_W-1:0]  member_align,
	input  logic                          is_bitfield,
	input  logic [smol_pkg::BITW_W-1:0]   bit_width,
	input  logic                          is_flexible,
	output smol_pkg::cmd_t                cmd
);

	logic                         union_mode_q;
	logic [smol_pkg::ALIGN_W-1:0] norm_align;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			union_mode_q <= 1'b0;
		end else if (cfg_we) begin
			union_mode_q <= cfg_wdata;
		end
	end

	// keep only the highest set bit, zero counts as one
	always_comb begin
		norm_align = smol_pkg::ALIGN_W'(1);
		for (int i = 0; i < smol_pkg::ALIGN_W; i++) begin
			if (member_align[i]) begin
				norm_align = smol_pkg::ALIGN_W'(1) << i;
			end
		end
	end

	always_comb begin
		cmd.align = norm_align;
		cmd.width = bit_width;
		cmd.tsize = is_flexible ? '0 : member_size;
		priority if (func) begin
			cmd.op = smol_pkg::OP_FINISH;
		end else if (union_mode_q) begin
			cmd.op = smol_pkg::OP_UNION;
		end else if (is_bitfield && (bit_width != '0)) begin
			cmd.op = smol_pkg::OP_BITS;
		end else begin
			cmd.op = smol_pkg::OP_PLAIN;
			// zero-width bitfield only aligns
			if (is_bitfield) begin
				cmd.tsize = '0;
			end
		end
	end

endmodule

>>> rtl/smol_back.sv
// back end: running layout state, close/align/add datapath and result build
module smol_back #(
	parameter int SIZE_BITS = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  smol_pkg::cmd_t cmd,
	output logic           cmd_take,
	input  logic           res_room,
	output smol_pkg::res_t res
);

	localparam int AW = smol_pkg::ALIGN_W;
	localparam int WS = ((SIZE_BITS > smol_pkg::BYTE_W) ? SIZE_BITS : smol_pkg::BYTE_W) + 1;

	logic [SIZE_BITS-1:0] run_q, run_d;
	logic [AW-1:0]        ralign_q, ralign_d;
	logic [2:0]           open_q, open_d;
	logic                 pad_q, pad_d;
	logic                 wrap_q, wrap_d;

	logic                 fire;
	logic                 au_c;
	logic [AW-1:0]        au_a;
	logic [AW-1:0]        am1;
	logic [SIZE_BITS:0]   au_sum;
	logic [SIZE_BITS-1:0] aligned;
	logic                 au_wrap;
	logic [AW-1:0]        low_sum;
	logic                 au_pad;
	logic [WS-1:0]        t_sum;
	logic                 t_wrap;
	logic [7:0]           post;
	logic [SIZE_BITS:0]   b_sum;
	logic [SIZE_BITS-1:0] tsz_n;
	logic [AW-1:0]        ralign_m;
	logic                 fin_empty;
	logic                 fin_cwrap;
	logic [SIZE_BITS-1:0] res_size;

	assign fire     = cmd_valid && res_room;
	assign cmd_take = fire;

	// close an open byte and align up in one add, carry-in is the close
	assign au_c    = (open_q != '0);
	assign au_a    = (cmd.op == smol_pkg::OP_FINISH) ? ralign_q : cmd.align;
	assign am1     = au_a - AW'(1);
	assign au_sum  = {1'b0, run_q} + (SIZE_BITS + 1)'(am1) + (SIZE_BITS + 1)'(au_c);
	assign aligned = au_sum[SIZE_BITS-1:0] & ~SIZE_BITS'(am1);
	assign au_wrap = au_sum[SIZE_BITS];
	assign low_sum = run_q[AW-1:0] + AW'(au_c);
	assign au_pad  = au_c || ((low_sum & am1) != '0);

	// member size added after alignment
	assign t_sum  = WS'(aligned) + WS'(cmd.tsize);
	assign t_wrap = |t_sum[WS-1:SIZE_BITS];

	// bitfield packing
	assign post  = {5'b0, open_q} + {1'b0, cmd.width};
	assign b_sum = {1'b0, run_q} + (SIZE_BITS + 1)'(post[7:3]);

	assign tsz_n    = SIZE_BITS'(cmd.tsize);
	assign ralign_m = (cmd.align > ralign_q) ? cmd.align : ralign_q;

	// size after closing the byte is zero
	assign fin_cwrap = au_c && (&run_q);
	assign fin_empty = au_c ? (&run_q) : (run_q == '0);

	always_comb begin
		run_d           = run_q;
		ralign_d        = ralign_q;
		open_d          = open_q;
		pad_d           = pad_q;
		wrap_d          = wrap_q;
		res_size        = '0;
		res.kind        = smol_pkg::KIND_MEMBER;
		res.bit_value   = '0;
		res.total_align = '0;
		unique case (cmd.op)
			smol_pkg::OP_PLAIN: begin
				ralign_d = ralign_m;
				open_d   = '0;
				run_d    = t_sum[SIZE_BITS-1:0];
				pad_d    = pad_q || au_pad;
				wrap_d   = wrap_q || au_wrap || t_wrap;
				res_size = aligned;
			end
			smol_pkg::OP_BITS: begin
				ralign_d      = ralign_m;
				open_d        = post[2:0];
				run_d         = b_sum[SIZE_BITS-1:0];
				wrap_d        = wrap_q || b_sum[SIZE_BITS];
				res_size      = run_q;
				res.bit_value = open_q;
			end
			smol_pkg::OP_UNION: begin
				ralign_d = ralign_m;
				if (tsz_n > run_q) begin
					run_d = tsz_n;
				end
			end
			smol_pkg::OP_FINISH: begin
				res.kind = smol_pkg::KIND_RECORD;
				if (fin_empty && (ralign_q == '0)) begin
					res_size        = '0;
					res.total_align = AW'(1);
					pad_d           = pad_q || au_c;
					wrap_d          = wrap_q || fin_cwrap;
				end else if (fin_empty) begin
					// empty record takes its alignment as its size
					res_size        = SIZE_BITS'(ralign_q);
					res.total_align = ralign_q;
					pad_d           = 1'b1;
					wrap_d          = wrap_q || fin_cwrap;
				end else begin
					res_size        = aligned;
					res.total_align = ralign_q;
					pad_d           = pad_q || au_pad;
					wrap_d          = wrap_q || au_wrap;
				end
			end
			default: begin
			end
		endcase
		res.byte_value = smol_pkg::BYTE_W'(res_size);
		res.padded     = pad_d;
		res.overflow   = wrap_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q    <= '0;
			ralign_q <= '0;
			open_q   <= '0;
			pad_q    <= 1'b0;
			wrap_q   <= 1'b0;
		end else if (fire) begin
			if (cmd.op == smol_pkg::OP_FINISH) begin
				run_q    <= '0;
				ralign_q <= '0;
				open_q   <= '0;
				pad_q    <= 1'b0;
				wrap_q   <= 1'b0;
			end else begin
				run_q    <= run_d;
				ralign_q <= ralign_d;
				open_q   <= open_d;
				pad_q    <= pad_d;
				wrap_q   <= wrap_d;
			end
		end
	end

endmodule

>>> rtl/smol_checker.sv
// port-level checks for the struct member offset layout block, bound to the top
module smol_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          empty,
	input logic                          pop,
	input logic                          kind,
	input logic [smol_pkg::BYTE_W-1:0]   byte_value,
	input logic [2:0]                    bit_value,
	input logic [smol_pkg::ALIGN_W-1:0]  total_align,
	input logic                          padded,
	input logic                          overflow
);

	// record beats carry a single power-of-two alignment
	a_record_align : assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (kind == smol_pkg::KIND_RECORD)) |-> $onehot(total_align))
		else $error("record beat without power-of-two alignment");

	// member beats report no alignment
	a_member_align : assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (kind == smol_pkg::KIND_MEMBER)) |-> (total_align == '0))
		else $error("member beat with nonzero alignment");

	// record beats carry no bit offset
	a_record_bit : assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (kind == smol_pkg::KIND_RECORD)) |-> (bit_value == '0))
		else $error("record beat with bit offset");

	// a waiting result stays put until taken
	a_hold : assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(byte_value) && $stable(kind)
			&& $stable(bit_value) && $stable(total_align) && $stable(padded)
			&& $stable(overflow)))
		else $error("waiting result changed before pop");

endmodule

bind struct_member_offset_layout smol_checker u_smol_checker (.*);
